/* sv/assert_macros.svh */
// Assertion macros used by the datapath of the event queue.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

/* sv/dedup_pkg.sv */
// Shared constants, types and a helper function of the deduplicating event queue.
package dedup_pkg;

  localparam int QUEUE_DEPTH = 128;
  localparam int EVENT_BITS  = 64;
  localparam int EVT_PORT_W  = 64;
  localparam int CNT_OUT_W   = 8;
  localparam int ADDR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W       = CNT_W + 1;

  typedef enum logic {
    OP_INSERT   = 1'b0,
    OP_RETRIEVE = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_RETRIEVED = 3'd3,
    ST_EMPTY     = 3'd4
  } status_t;

  typedef struct packed {
    logic load;
    logic scan_en;
    logic rd_head;
    logic commit;
  } dedup_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic out_free;
  } dedup_sts_t;

  // Adds an offset below the depth to a slot index and wraps it into the queue.
  function automatic logic [ADDR_W-1:0] wrap_add(input logic [ADDR_W-1:0] base,
                                                 input logic [CNT_W-1:0] off);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(base) + SUM_W'(off);
    if (sum >= SUM_W'(QUEUE_DEPTH)) begin
      sum = sum - SUM_W'(QUEUE_DEPTH);
    end
    return ADDR_W'(sum);
  endfunction

endpackage

/* sv/dedup_event_fifo_top.sv */
// Top level of the deduplicating event queue.
//
// The input channel carries one operation per beat: insert an event word, or
// retrieve the oldest queued word. Every input beat yields exactly one result
// beat with a status code, the retrieved word (zero unless retrieved) and the
// number of queued events after the operation.
// An insert first reads every queued entry from the slot memory, one per
// cycle, and stops early on a match; its result is then written to the
// result register. The slot memory has a single read port. A retrieve reads
// the head entry and then writes its result. The result beat becomes valid
// in the same cycle in which in_ready rises again.
// One operation is in flight at a time; in_ready is high only while idle.
// The result register holds a finished beat while the next input beat is
// taken. When the receiver stalls, a further finished result waits inside
// until the register frees, and no state changes until it is written.
// Reset empties the queue and clears head and count at once; slot contents
// are left as they are and never used before being written.
module dedup_event_fifo_top
  import dedup_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_operation,
  input  logic [EVT_PORT_W-1:0] in_event_in,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [2:0]            out_status,
  output logic [EVT_PORT_W-1:0] out_event_out,
  output logic [CNT_OUT_W-1:0]  out_queue_count
);

  dedup_cmd_t cmd;
  dedup_sts_t sts;

  dedup_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_operation (in_operation),
    .cmd          (cmd),
    .sts          (sts)
  );

  dedup_dpath u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_operation    (in_operation),
    .in_event_in     (in_event_in),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_event_out   (out_event_out),
    .out_queue_count (out_queue_count)
  );

endmodule

/* sv/dedup_dpath.sv */
// Datapath of the event queue: slot memory, pointers, duplicate scan and result register.
`include "assert_macros.svh"

module dedup_dpath
  import dedup_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  dedup_cmd_t            cmd,
  output dedup_sts_t            sts,
  input  logic                  in_operation,
  input  logic [EVT_PORT_W-1:0] in_event_in,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [2:0]            out_status,
  output logic [EVT_PORT_W-1:0] out_event_out,
  output logic [CNT_OUT_W-1:0]  out_queue_count
);

  logic [EVENT_BITS-1:0] slot_mem [QUEUE_DEPTH];

  logic                  op_r;
  logic [EVENT_BITS-1:0] word_r;
  logic [ADDR_W-1:0]     head_r, head_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [CNT_W-1:0]      idx_r;
  logic                  hit_r;
  logic                  rd_pend_r;
  logic [EVENT_BITS-1:0] rd_data_r;

  logic                  out_valid_r;
  status_t               out_status_r, out_status_nxt;
  logic [EVENT_BITS-1:0] out_event_r, out_event_nxt;
  logic [CNT_W-1:0]      out_count_r;

  logic                  scan_rd;
  logic                  rd_en;
  logic [ADDR_W-1:0]     rd_addr;
  logic                  wr_en;
  logic [ADDR_W-1:0]     wr_addr;
  logic                  out_free;

  assign scan_rd  = cmd.scan_en && (idx_r != count_r);
  assign rd_en    = cmd.rd_head || scan_rd;
  assign rd_addr  = cmd.rd_head ? head_r : wrap_add(head_r, idx_r);
  assign wr_addr  = wrap_add(head_r, count_r);
  assign out_free = !out_valid_r || out_ready;

  assign sts.scan_done = hit_r || ((idx_r == count_r) && !rd_pend_r);
  assign sts.out_free  = out_free;

  always_comb begin
    head_nxt       = head_r;
    count_nxt      = count_r;
    wr_en          = 1'b0;
    out_status_nxt = ST_EMPTY;
    out_event_nxt  = '0;
    if (op_r == OP_INSERT) begin
      if (hit_r) begin
        out_status_nxt = ST_DUPLICATE;
      end else if (count_r == CNT_W'(QUEUE_DEPTH)) begin
        out_status_nxt = ST_FULL;
      end else begin
        out_status_nxt = ST_INSERTED;
        wr_en          = cmd.commit;
        count_nxt      = count_r + CNT_W'(1);
      end
    end else begin
      if (count_r == '0) begin
        out_status_nxt = ST_EMPTY;
      end else begin
        out_status_nxt = ST_RETRIEVED;
        out_event_nxt  = rd_data_r;
        count_nxt      = count_r - CNT_W'(1);
        head_nxt       = (count_r == CNT_W'(1)) ? '0 : wrap_add(head_r, CNT_W'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_mem[wr_addr] <= word_r;
    end
    if (rd_en) begin
      rd_data_r <= slot_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= in_operation;
      word_r <= in_event_in[EVENT_BITS-1:0];
    end
    if (cmd.commit) begin
      out_status_r <= out_status_nxt;
      out_event_r  <= out_event_nxt;
      out_count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      count_r     <= '0;
      idx_r       <= '0;
      hit_r       <= 1'b0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        idx_r     <= '0;
        hit_r     <= 1'b0;
        rd_pend_r <= 1'b0;
      end else begin
        rd_pend_r <= scan_rd;
        if (scan_rd) begin
          idx_r <= idx_r + CNT_W'(1);
        end
        if (rd_pend_r && (rd_data_r == word_r)) begin
          hit_r <= 1'b1;
        end
      end
      if (cmd.commit) begin
        head_r      <= head_nxt;
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_event_out   = EVT_PORT_W'(out_event_r);
  assign out_queue_count = CNT_OUT_W'(out_count_r);

  `ASSERT_ALWAYS(a_count_range, count_r <= CNT_W'(QUEUE_DEPTH), "entry count above depth")
  `ASSERT_ALWAYS(a_head_range, CNT_W'(head_r) < CNT_W'(QUEUE_DEPTH), "head outside queue")
  `ASSERT_IMPLY(a_empty_head, count_r == '0, head_r == '0, "empty queue with nonzero head")
  `ASSERT_ALWAYS(a_scan_bound, idx_r <= count_r, "scan index past entry count")
  `ASSERT_IMPLY(a_commit_free, cmd.commit, out_free, "result written over a held beat")

endmodule

/* sv/dedup_ctrl.sv */
// Controller of the event queue: sequences the scan, the head read and the result.
module dedup_ctrl
  import dedup_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_operation,
  output dedup_cmd_t cmd,
  input  dedup_sts_t sts
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_RETR,
    S_RESULT
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  assign cmd.load    = accept;
  assign cmd.scan_en = (state_r == S_SCAN);
  assign cmd.rd_head = (state_r == S_RETR);
  assign cmd.commit  = (state_r == S_RESULT) && sts.out_free;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = (in_operation == OP_RETRIEVE) ? S_RETR : S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.scan_done) begin
          state_nxt = S_RESULT;
        end
      end
      S_RETR: begin
        state_nxt = S_RESULT;
      end
      S_RESULT: begin
        if (sts.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
